// File: design/assert_macros.svh
// Assertion macros used by the RTL top level.
// Define NO_ASSERTIONS to compile every macro use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/sfls_pkg.sv
// Types and constants of the sorted first/last search block.
// No dependencies; used by the top level, the result checker and the testbench.
package sfls_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_FIRST = 2'd1,
        ACT_LAST  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_MISS
    } t_state;

    typedef struct packed {
        t_action                    action;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [VALUE_W-1:0]  entry_value;
        logic signed [VALUE_W-1:0]  search_key;
    } t_in_req;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
    } t_out_res;

endpackage

// File: design/sfls_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing; instanced by the search top level.
module sfls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: design/sorted_first_last_search.sv
// A write request stores one value. A find request is accepted and then makes one
// binary-search probe at a time, at most floor(log2(n))+1 probes for n covered entries;
// each probe is one read of the store RAM, whose two read ports return the probed entry
// and its neighbor together.
// The result register lets the next request be accepted while a result waits; a
// search that finishes while the previous result is still stalled holds in place.
// Top level of the sorted first/last search; uses sfls_pkg, sfls_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module sorted_first_last_search
    import sfls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_res            o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi1, n_hi1;
    logic [CW-1:0]        r_mid, n_mid;
    logic [VALUE_W-1:0]   r_key, n_key;
    logic                 r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    t_out_res             r_out, n_out;

    logic                 in_acc;
    logic                 can_finish;
    logic [CW-1:0]        clamp_n;
    logic                 we;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic [VALUE_W-1:0]   rd_a, rd_b;
    logic                 eq, hit, go_right;
    logic [CW-1:0]        lo_nx, hi_nx;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign can_finish  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign clamp_n = (32'(r_count) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(r_count);
    assign we      = in_acc && (i_in.action == ACT_WRITE) && (32'(i_in.entry_index) < 32'(DEPTH));

    assign raddr_a = AW'(n_mid);
    assign raddr_b = n_last ? AW'(n_mid + CW'(1)) : AW'(n_mid - CW'(1));

    sfls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (AW'(i_in.entry_index)),
        .i_wdata   (i_in.entry_value),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        eq = ($signed(rd_a) == $signed(r_key));
        if (!r_last) begin
            hit      = ((r_mid == '0) || ($signed(rd_b) < $signed(r_key))) && eq;
            go_right = ($signed(rd_a) < $signed(r_key));
        end else begin
            hit      = ((r_mid == r_n - CW'(1)) || ($signed(rd_b) > $signed(r_key))) && eq;
            go_right = !($signed(rd_a) > $signed(r_key));
        end
        lo_nx = go_right ? r_mid + CW'(1) : r_lo;
        hi_nx = go_right ? r_hi1 : r_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
        r_n    <= n_n;
        r_lo   <= n_lo;
        r_hi1  <= n_hi1;
        r_mid  <= n_mid;
        r_key  <= n_key;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_key       = r_key;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.action == ACT_FIRST || i_in.action == ACT_LAST)) begin
                    n_key  = i_in.search_key;
                    n_last = (i_in.action == ACT_LAST);
                    n_n    = clamp_n;
                    n_lo   = '0;
                    n_hi1  = clamp_n;
                    if (clamp_n == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_mid   = (clamp_n - CW'(1)) >> 1;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (hit || (lo_nx >= hi_nx)) begin
                    if (can_finish) begin
                        n_out_valid    = 1'b1;
                        n_out.found    = hit;
                        n_out.position = hit ? POS_W'(r_mid) : '0;
                        n_state        = S_IDLE;
                    end
                end else begin
                    n_lo  = lo_nx;
                    n_hi1 = hi_nx;
                    n_mid = lo_nx + ((hi_nx - lo_nx - CW'(1)) >> 1);
                end
            end
            S_MISS: begin
                if (can_finish) begin
                    n_out_valid    = 1'b1;
                    n_out.found    = 1'b0;
                    n_out.position = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NOW(a_range_open, i_clk, i_rst_n, (r_state != S_PROBE) || (r_lo < r_hi1), "probe with empty range")
    `ASSERT_NOW(a_mid_in_range, i_clk, i_rst_n, (r_state != S_PROBE) || ((r_mid >= r_lo) && (r_mid < r_hi1)), "probe position outside range")
    `ASSERT_NOW(a_hi_bound, i_clk, i_rst_n, (r_state != S_PROBE) || (r_hi1 <= r_n), "upper bound beyond count")
    `ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid && (r_out == $past(r_out)), "pending result overwritten")

endmodule

// File: test/sfls_search_check.sv
`timescale 1ns / 100ps
// Result checker for the sorted first/last search block: follows the request, result and
// configuration ports, predicts every find result and compares it with what comes out.
// Depends on sfls_pkg only.
module sfls_search_check
    import sfls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_req             i_in_req,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_res            i_out_res,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic signed [VALUE_W-1:0] store_copy [DEPTH];
    logic [COUNT_W-1:0]        span;
    t_out_res                  results_due [$];

    function automatic t_out_res search_store(input logic signed [VALUE_W-1:0] key,
                                              input bit want_last);
        int n;
        int lo;
        int hi;
        int mid;
        t_out_res res;
        n = (int'(span) > DEPTH) ? DEPTH : int'(span);
        lo = 0;
        hi = n - 1;
        res = '0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (!want_last) begin
                if ((mid == 0 || store_copy[mid - 1] < key) && store_copy[mid] == key) begin
                    res.found = 1'b1;
                    res.position = POS_W'(mid);
                    return res;
                end
                if (store_copy[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end else begin
                if ((mid == n - 1 || store_copy[mid + 1] > key) && store_copy[mid] == key) begin
                    res.found = 1'b1;
                    res.position = POS_W'(mid);
                    return res;
                end
                if (store_copy[mid] > key) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : follow_ports
        t_out_res due;
        if (!i_rst_n) begin
            span = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                span = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_req.action)
                    ACT_WRITE: store_copy[i_in_req.entry_index] = i_in_req.entry_value;
                    ACT_FIRST: results_due.push_back(search_store(i_in_req.search_key, 1'b0));
                    ACT_LAST:  results_due.push_back(search_store(i_in_req.search_key, 1'b1));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with none expected: found %0b position %0d",
                             $time, i_out_res.found, i_out_res.position);
                    o_fail_count++;
                end else begin
                    due = results_due.pop_front();
                    if (i_out_res.found !== due.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, due.found, i_out_res.found);
                        o_fail_count++;
                    end
                    if (i_out_res.position !== due.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, due.position, i_out_res.position);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// File: test/tb_sorted_first_last_search.sv
`timescale 1ns / 100ps
// Testbench top of the sorted first/last search block: loads sorted stores, sets the
// element count, sends find requests under random stalls and gives the verdict.
// Depends on sfls_pkg, sorted_first_last_search and sfls_search_check.
module tb_sorted_first_last_search;
    import sfls_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int N_ITEMS     = 1350;
    localparam int QUIET_TAIL  = 120;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 16;
    localparam int DRAIN_LIMIT = 2000;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_req            i_in = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_res           o_out;
    int                 fail_count;
    int                 pending;

    int                        sent;
    int                        span;
    bit                        quiet;
    bit                        hold_req;
    bit                        hold_done;
    logic signed [VALUE_W-1:0] loaded [DEPTH];

    sorted_first_last_search #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    sfls_search_check #(.DEPTH(DEPTH)) search_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_res    (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    initial begin : result_stall
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 63) == 0) begin
                gap = $urandom_range(20, 80);
                repeat (gap) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                gap = $urandom_range(1, 16);
                repeat (gap) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_req(input t_action act, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] value,
                            input logic signed [VALUE_W-1:0] key);
        int gap;
        if (sent >= N_ITEMS - QUIET_TAIL) begin
            quiet = 1'b1;
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        i_in.action = act;
        i_in.entry_index = idx;
        i_in.entry_value = value;
        i_in.search_key = key;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic put_entry(input int idx, input logic signed [VALUE_W-1:0] value);
        loaded[idx] = value;
        send_req(ACT_WRITE, INDEX_W'(idx), value, $urandom);
    endtask

    task automatic set_span(input int n);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = COUNT_W'(n);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        span = n;
    endtask

    task automatic load_run(input int n);
        longint level;
        int top_idx;
        top_idx = (n < DEPTH) ? n : DEPTH - 1;
        level = longint'($signed($urandom)) / (longint'(1) << $urandom_range(0, 12));
        if ($urandom_range(0, 4) == 0) begin
            level = V_MIN;
        end
        for (int k = 0; k <= top_idx; k++) begin
            put_entry(k, VALUE_W'(level));
            case ($urandom_range(0, 3))
                0: ;
                1, 2: level += $urandom_range(1, 40);
                default: level += $urandom_range(1, 1 << 24);
            endcase
            if (level > V_MAX) begin
                level = V_MAX;
            end
        end
    endtask

    task automatic search_run(input int count);
        int nn;
        int pick;
        logic signed [VALUE_W-1:0] key;
        nn = (span < DEPTH) ? span : DEPTH;
        repeat (count) begin
            pick = $urandom_range(0, 39);
            key = $urandom;
            if (nn > 0) begin
                if (pick < 22) begin
                    key = loaded[$urandom_range(0, nn - 1)];
                end else if (pick < 26) begin
                    key = loaded[$urandom_range(0, nn - 1)] + ($urandom_range(0, 1) ? 1 : -1);
                end else if (pick < 29 && loaded[0] != V_MIN) begin
                    key = loaded[0] - 1;
                end else if (pick < 32 && loaded[nn - 1] != V_MAX) begin
                    key = loaded[nn - 1] + 1;
                end
            end
            if (pick == 38) begin
                put_entry($urandom_range(0, (nn < DEPTH) ? nn : DEPTH - 1), $urandom);
            end else if (pick == 39) begin
                send_req(t_action'(ACT_NONE), INDEX_W'($urandom), $urandom, $urandom);
            end else begin
                send_req($urandom_range(0, 1) ? ACT_LAST : ACT_FIRST, INDEX_W'($urandom),
                         $urandom, key);
            end
        end
    endtask

    initial begin : stimulus
        int n;
        int waited;
        logic signed [VALUE_W-1:0] dir_vals [10];
        dir_vals = '{V_MIN, V_MIN, -32'sd7, 32'sd0, 32'sd0, 32'sd0, 32'sd5, V_MAX, V_MAX, V_MAX};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty store, then a short store with duplicates at both extremes.
        send_req(ACT_FIRST, '0, '0, '0);
        send_req(ACT_LAST, INDEX_W'(DEPTH - 1), V_MAX, V_MIN);
        send_req(t_action'(ACT_NONE), INDEX_W'(DEPTH - 1), V_MIN, V_MAX);
        set_span(9);
        for (int k = 0; k < 10; k++) begin
            put_entry(k, dir_vals[k]);
        end
        send_req(ACT_FIRST, '0, '0, V_MIN);
        send_req(ACT_LAST, '0, '0, V_MIN);
        send_req(ACT_FIRST, '0, '0, 32'sd0);
        send_req(ACT_LAST, '0, '0, 32'sd0);
        send_req(ACT_FIRST, '0, '0, V_MAX);
        send_req(ACT_LAST, '0, '0, V_MAX);
        send_req(ACT_FIRST, '0, '0, -32'sd1);
        send_req(ACT_LAST, '0, '0, 32'sd6);

        // Full store, then a count beyond the store depth.
        set_span(DEPTH);
        load_run(DEPTH);
        search_run(60);
        set_span((1 << COUNT_W) - 1);
        search_run(30);

        while (sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0: n = 0;
                1: n = 1;
                2: n = $urandom_range(100, 300);
                default: n = $urandom_range(2, 48);
            endcase
            set_span(n);
            load_run(n);
            hold_req = 1'b1;
            search_run($urandom_range(20, 40));
        end

        i_in_valid = 1'b0;
        for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sfls_pkg.sv
design/sfls_ram.sv
design/sorted_first_last_search.sv
test/sfls_search_check.sv
test/tb_sorted_first_last_search.sv
